// ----- rtl/trle_pkg.sv -----
// Shared types and constants for the transparent run line encoder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package trle_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF     = 128;
    localparam int BEAT_BYTES_DEF    = 8;
    localparam int MAX_SOLID_RUN_DEF = 125;

    // Byte lanes present on the output port, whatever the beat size
    localparam int PORT_BYTES = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_INDEX = 8'd1;
    localparam logic [7:0] LINE_WIDTH_RESET  = 8'd128;
    localparam logic [7:0] TRANS_INDEX_RESET = 8'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HDR,
        S_BODY,
        S_UPD,
        S_END
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch the incoming pixel
        logic hdr_push;    // push the header byte of the open run
        logic body_run;    // stream the stored pixels of the open run
        logic run_clear;   // close the open run
        logic clear_kind;  // also reset the run kind on close
        logic update;      // fold the latched pixel into the run state
        logic end_push;    // send the partial beat as the final beat
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic flush_needed; // run kind changes with the latched pixel
        logic line_done;    // latched pixel ends its line
        logic run_solid;    // open run is a solid run
        logic pack_ready;   // packer takes a byte this cycle
        logic slot_free;    // output register can be loaded this cycle
        logic body_done;    // all stored pixels of the run were pushed
        logic fill_zero;    // packer holds no byte
    } status_t;

endpackage

// ----- rtl/trle_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module trle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and read with the data held until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/trle_ctrl.sv -----
// Sequencer of the encoder: steps one pixel through flush, update and beat output.
// Depends on trle_pkg.
`timescale 1ns / 1ps

module trle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  trle_pkg::status_t status,
    output trle_pkg::cmd_t    cmd
);

    import trle_pkg::*;

    state_t state_reg, state_next;
    logic   second_reg, second_next;   // flushing at line end, not on kind change

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                second_next = 1'b0;
                state_next  = status.flush_needed ? S_HDR : S_UPD;
            end
            S_HDR:
            begin
                if (status.pack_ready)
                begin
                    if (status.run_solid)
                    begin
                        state_next = S_BODY;
                    end
                    else
                    begin
                        state_next = second_reg ? S_END : S_UPD;
                    end
                end
            end
            S_BODY:
            begin
                if (status.body_done)
                begin
                    state_next = second_reg ? S_END : S_UPD;
                end
            end
            S_UPD:
            begin
                if (status.line_done)
                begin
                    second_next = 1'b1;
                    state_next  = S_HDR;
                end
                else
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (status.fill_zero || status.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        pixel_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                pixel_ready = 1'b1;
                cmd.accept  = pixel_valid;
            end
            S_HDR:
            begin
                if (status.pack_ready)
                begin
                    cmd.hdr_push = 1'b1;
                    if (!status.run_solid)
                    begin
                        cmd.run_clear  = 1'b1;
                        cmd.clear_kind = second_reg;
                    end
                end
            end
            S_BODY:
            begin
                cmd.body_run = 1'b1;
                if (status.body_done)
                begin
                    cmd.run_clear  = 1'b1;
                    cmd.clear_kind = second_reg;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
            end
            S_END:
            begin
                cmd.end_push = !status.fill_zero && status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/trle_datapath.sv -----
// Datapath of the encoder: run state, run store, byte packer and output register.
// Depends on trle_pkg and trle_ram.
`timescale 1ns / 1ps

module trle_datapath #(
    parameter int MAX_WIDTH     = trle_pkg::MAX_WIDTH_DEF,
    parameter int BEAT_BYTES    = trle_pkg::BEAT_BYTES_DEF,
    parameter int MAX_SOLID_RUN = trle_pkg::MAX_SOLID_RUN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [7:0]                       pixel,
    input  logic                             cfg_write,
    input  logic [trle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    input  trle_pkg::cmd_t                   cmd,
    output trle_pkg::status_t                status,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [7:0]                       out_bytes [trle_pkg::PORT_BYTES],
    output logic [3:0]                       out_count,
    output logic                             out_end,
    output logic                             out_flag,
    output logic                             out_last
);

    import trle_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int FW = $clog2(BEAT_BYTES + 1);

    // Configuration registers
    logic [7:0] line_width_reg;
    logic [7:0] trans_idx_reg;

    // Run state
    logic [CW-1:0] run_count_reg;
    logic          in_trans_reg;
    logic [AW-1:0] column_reg;

    // Latched pixel
    logic [7:0] pix_reg;
    logic       pix_trans_reg;
    logic       line_done_reg;

    // Store read stream
    logic [CW-1:0] rd_issue_reg;
    logic [CW-1:0] rd_done_reg;
    logic          rd_pend_reg;
    logic          rd_en;
    logic          rd_take;
    logic [7:0]    rd_data;

    // Packer and output register
    logic [7:0]    pack_reg [BEAT_BYTES];
    logic [7:0]    pack_next [BEAT_BYTES];
    logic [FW-1:0] fill_reg, fill_next;
    logic          pflag_reg, pflag_next;
    logic [7:0]    obytes_reg [BEAT_BYTES];
    logic [7:0]    obytes_next [BEAT_BYTES];
    logic [FW-1:0] ocount_reg, ocount_next;
    logic          ovalid_reg, ovalid_next;
    logic          olast_reg, olast_next;
    logic          oend_reg, oend_next;
    logic          oflag_reg, oflag_next;

    logic [7:0] w_eff;
    logic       line_done_now;
    logic [7:0] run_cnt8;
    logic       run_long;
    logic [7:0] hdr_byte;
    logic       byte_push;
    logic [7:0] byte_in;
    logic       byte_flag;
    logic       slot_free;
    logic       pack_full;
    logic       store_wr;

    // Configuration writes; other indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            trans_idx_reg  <= TRANS_INDEX_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_LINE_WIDTH)
            begin
                line_width_reg <= cfg_data;
            end
            else if (cfg_index == REG_TRANSPARENT_INDEX)
            begin
                trans_idx_reg <= cfg_data;
            end
        end
    end

    // Effective line width: zero acts as one, saturate at the store depth
    always_comb
    begin
        if (line_width_reg == 8'd0)
        begin
            w_eff = 8'd1;
        end
        else if ({1'b0, line_width_reg} > 9'(MAX_WIDTH))
        begin
            w_eff = 8'(MAX_WIDTH);
        end
        else
        begin
            w_eff = line_width_reg;
        end
    end

    assign line_done_now = (9'(column_reg) + 9'd1) >= {1'b0, w_eff};

    // Latch the accepted pixel and its classification
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg       <= pixel;
            pix_trans_reg <= (pixel == trans_idx_reg);
            line_done_reg <= line_done_now;
        end
    end

    // Run state: close on flush, extend on update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
            in_trans_reg  <= 1'b0;
            column_reg    <= '0;
        end
        else if (cmd.run_clear)
        begin
            run_count_reg <= '0;
            if (cmd.clear_kind)
            begin
                in_trans_reg <= 1'b0;
            end
        end
        else if (cmd.update)
        begin
            if (run_count_reg == '0)
            begin
                in_trans_reg <= pix_trans_reg;
            end
            run_count_reg <= run_count_reg + CW'(1);
            column_reg    <= line_done_reg ? '0 : column_reg + AW'(1);
        end
    end

    assign store_wr = cmd.update && !pix_trans_reg && (run_count_reg < CW'(MAX_WIDTH));

    // Header byte and long-run flag of the open run
    assign run_cnt8 = 8'(run_count_reg);
    assign run_long = !in_trans_reg && (run_cnt8 > 8'(MAX_SOLID_RUN));
    assign hdr_byte = in_trans_reg ? 8'(9'd256 - {1'b0, run_cnt8}) : run_cnt8;

    // Stream the stored pixels through the registered read port
    assign rd_take = cmd.body_run && rd_pend_reg && status.pack_ready;
    assign rd_en   = cmd.body_run && (rd_issue_reg < run_count_reg)
                     && (!rd_pend_reg || rd_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_issue_reg <= '0;
            rd_done_reg  <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else if (cmd.hdr_push)
        begin
            rd_issue_reg <= '0;
            rd_done_reg  <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_issue_reg <= rd_issue_reg + CW'(1);
            end
            if (rd_take)
            begin
                rd_done_reg <= rd_done_reg + CW'(1);
            end
            if (rd_en)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (rd_take)
            begin
                rd_pend_reg <= 1'b0;
            end
        end
    end

    trle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (run_count_reg[AW-1:0]),
        .wr_data (pix_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Byte source into the packer
    assign byte_push = cmd.hdr_push || rd_take;
    assign byte_in   = cmd.hdr_push ? hdr_byte : rd_data;
    assign byte_flag = run_long;

    assign slot_free = !ovalid_reg || out_ready;
    assign pack_full = (fill_reg == FW'(BEAT_BYTES));

    // Pack bytes into beats; a full beat waits until a further byte shows it is not final
    always_comb
    begin
        pack_next   = pack_reg;
        fill_next   = fill_reg;
        pflag_next  = pflag_reg;
        obytes_next = obytes_reg;
        ocount_next = ocount_reg;
        olast_next  = olast_reg;
        oend_next   = oend_reg;
        oflag_next  = oflag_reg;
        ovalid_next = ovalid_reg && !out_ready;

        if (byte_push)
        begin
            if (pack_full)
            begin
                obytes_next   = pack_reg;
                ocount_next   = fill_reg;
                olast_next    = 1'b0;
                oend_next     = 1'b0;
                oflag_next    = pflag_reg;
                ovalid_next   = 1'b1;
                pack_next[0]  = byte_in;
                fill_next     = FW'(1);
                pflag_next    = byte_flag;
            end
            else
            begin
                for (int j = 0; j < BEAT_BYTES; j++)
                begin
                    if (fill_reg == FW'(j))
                    begin
                        pack_next[j] = byte_in;
                    end
                end
                fill_next  = fill_reg + FW'(1);
                pflag_next = pflag_reg || byte_flag;
            end
        end
        else if (cmd.end_push)
        begin
            for (int j = 0; j < BEAT_BYTES; j++)
            begin
                obytes_next[j] = (FW'(j) < fill_reg) ? pack_reg[j] : 8'd0;
            end
            ocount_next = fill_reg;
            olast_next  = 1'b1;
            oend_next   = line_done_reg;
            oflag_next  = pflag_reg;
            ovalid_next = 1'b1;
            fill_next   = '0;
            pflag_next  = 1'b0;
        end
    end

    // Control part of the packer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            pflag_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            pflag_reg  <= pflag_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload part of the packer and output register
    always_ff @(posedge clk)
    begin
        pack_reg   <= pack_next;
        obytes_reg <= obytes_next;
        ocount_reg <= ocount_next;
        olast_reg  <= olast_next;
        oend_reg   <= oend_next;
        oflag_reg  <= oflag_next;
    end

    // Status to the controller
    always_comb
    begin
        status.flush_needed = (run_count_reg != '0) && (pix_trans_reg != in_trans_reg);
        status.line_done    = line_done_reg;
        status.run_solid    = !in_trans_reg;
        status.pack_ready   = !pack_full || slot_free;
        status.slot_free    = slot_free;
        status.body_done    = (rd_done_reg == run_count_reg);
        status.fill_zero    = (fill_reg == '0);
    end

    // Output word; lanes beyond the beat size read zero
    for (genvar j = 0; j < PORT_BYTES; j++)
    begin : g_lane
        if (j < BEAT_BYTES)
        begin : g_used
            assign out_bytes[j] = obytes_reg[j];
        end
        else
        begin : g_unused
            assign out_bytes[j] = 8'd0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_count = 4'(ocount_reg);
    assign out_end   = oend_reg;
    assign out_flag  = oflag_reg;
    assign out_last  = olast_reg;

endmodule

// ----- rtl/transparent_run_line_encoder_core.sv -----
// Sequence: a pixel that only extends its run steps through the idle, decide, update and end
// states before the next accept. A flushed transparent run adds a header step; a solid run
// adds a header step, then one store read per pixel and the close in the body state; the final
// beat of a pixel is loaded in the end state. Header, body and end may stall on beat_ready. One pixel at a time.
// Reset: rst_n is asynchronous, active low; run state and control registers are reset;
// payload registers and the run store are not cleared, and the store needs no clearing pass.
`timescale 1ns / 1ps

module transparent_run_line_encoder_core #(
    parameter int MAX_WIDTH     = trle_pkg::MAX_WIDTH_DEF,
    parameter int BEAT_BYTES    = trle_pkg::BEAT_BYTES_DEF,
    parameter int MAX_SOLID_RUN = trle_pkg::MAX_SOLID_RUN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [7:0]                       pixel,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    output logic                             beat_valid,
    input  logic                             beat_ready,
    output logic [7:0]                       byte0,
    output logic [7:0]                       byte1,
    output logic [7:0]                       byte2,
    output logic [7:0]                       byte3,
    output logic [7:0]                       byte4,
    output logic [7:0]                       byte5,
    output logic [7:0]                       byte6,
    output logic [7:0]                       byte7,
    output logic [3:0]                       valid_bytes,
    output logic                             line_end,
    output logic                             run_too_long,
    output logic                             last
);

    import trle_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic [7:0] lane [PORT_BYTES];

    // Registers accept a write in every cycle
    assign cfg_ready = 1'b1;

    trle_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .status      (status),
        .cmd         (cmd)
    );

    trle_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .BEAT_BYTES    (BEAT_BYTES),
        .MAX_SOLID_RUN (MAX_SOLID_RUN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (beat_ready),
        .out_valid (beat_valid),
        .out_bytes (lane),
        .out_count (valid_bytes),
        .out_end   (line_end),
        .out_flag  (run_too_long),
        .out_last  (last)
    );

    assign byte0 = lane[0];
    assign byte1 = lane[1];
    assign byte2 = lane[2];
    assign byte3 = lane[3];
    assign byte4 = lane[4];
    assign byte5 = lane[5];
    assign byte6 = lane[6];
    assign byte7 = lane[7];

`ifndef NO_ASSERTIONS
    // A shown word always carries at least one byte and no more than a beat
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid |-> (valid_bytes != 4'd0) && (valid_bytes <= 4'(BEAT_BYTES)))
        else $error("beat word with bad byte count");

    // Only the final word of a pixel may be partial
    a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid && !last |-> valid_bytes == 4'(BEAT_BYTES))
        else $error("partial beat word that is not final");

    // End of line is marked only on the final word of a pixel
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid && line_end |-> last)
        else $error("line end on a non-final word");

    // One pixel at a time: no accept in the cycle after an accept
    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("pixel accepted while the previous one is in work");
`endif

endmodule
